// File: hw/rtl/urx_brk_pkg.sv
package urx_brk_pkg;

    typedef enum logic [1:0] {
        CMD_RX    = 2'd0,
        CMD_READ  = 2'd1,
        CMD_PEEK  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        BRK_IDLE  = 2'd0,
        BRK_SEEN  = 2'd1,
        BRK_RESET = 2'd2
    } brk_state_t;

    localparam logic [7:0] RESET_CHAR = 8'h72;
    localparam int         FILL_W     = 7;
    localparam int         BYTE_W     = 8;

endpackage

// File: hw/rtl/uart_rx_fifo_break_reset_detect_unit.sv
// UART receive FIFO with break / reset-character detector.
//
// Input channel (s_*): one command item per transfer. s_tuser carries the
// command (receive, read, peek, clear); s_tdata carries the received byte,
// its valid bit and its framing-error bit.
// Result channel (m_*): exactly one result item per command, in order:
// the byte read or peeked with its present flag, the fill count after the
// command, the reset-seen flag and the one-shot reset pulse.
// Configuration channel (cfg_*): the receiver enable bit, always ready.
// Write it only while no command is in flight.
//
// Per command, the accept cycle updates pointers and the detector and
// issues at most one access to the FIFO RAM; the collect state (S_DATA) then
// loads the registered RAM read data into the output register once it is
// free, so no new command is accepted while one is in flight.
// Input is taken again as soon as the result is in the output register,
// even if it has not been taken yet; a stalled result only holds the
// collect step until the output register frees up.
// Reset empties the FIFO, returns the detector to idle and disables the
// receiver. FIFO contents need no clearing; no clearing pass is run.
module uart_rx_fifo_break_reset_detect_unit
    import urx_brk_pkg::*;
#(
    parameter int FIFO_DEPTH = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] rx_byte, [8] rx_valid, [9] frame_error
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] data, [14:8] fill_count, [15] reset_flag,
                                   // [16] reset_pulse
    output logic [0:0]  m_tuser,   // [0] data_present
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_data   // [0] enabled
);

    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = PW + 1;
    localparam logic [PW-1:0] LAST_IDX = PW'(FIFO_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(FIFO_DEPTH);

    typedef enum logic {
        S_IDLE,
        S_DATA
    } state_t;

    state_t            state_reg, state_next;
    logic [PW-1:0]     wp_reg, wp_next;
    logic [PW-1:0]     rp_reg, rp_next;
    brk_state_t        brk_reg, brk_next;
    logic              enabled_reg;
    logic              present_reg;
    logic [FILL_W-1:0] fill_reg;
    logic              flag_reg;
    logic              pulse_reg;
    logic              m_valid_reg, m_valid_next;
    logic [23:0]       m_tdata_reg;
    logic [0:0]        m_tuser_reg;

    logic              in_accept;
    cmd_t              cmd;
    logic [BYTE_W-1:0] rx_byte;
    logic              ferr;
    logic              not_empty;
    logic [PW-1:0]     wp_inc, rp_inc;
    logic              push, pop, present;
    logic              pulse;
    logic [CW-1:0]     fill_raw;
    logic              out_load;
    logic [BYTE_W-1:0] rd_data;

    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign cmd       = cmd_t'(s_tuser);
    assign rx_byte   = s_tdata[8] ? s_tdata[7:0] : '0;
    assign ferr      = s_tdata[8] && s_tdata[9];
    assign not_empty = (wp_reg != rp_reg);
    assign wp_inc    = (wp_reg == LAST_IDX) ? '0 : wp_reg + 1'b1;
    assign rp_inc    = (rp_reg == LAST_IDX) ? '0 : rp_reg + 1'b1;

    assign push    = in_accept && (cmd == CMD_RX) && enabled_reg && (wp_inc != rp_reg);
    assign pop     = in_accept && (cmd == CMD_READ) && not_empty;
    assign present = in_accept && ((cmd == CMD_READ) || (cmd == CMD_PEEK)) && not_empty;

    // Break detector and pointer updates
    always_comb begin
        brk_next = brk_reg;
        pulse    = 1'b0;
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        if (in_accept) begin
            unique case (cmd)
                CMD_RX: begin
                    if (ferr && enabled_reg) begin
                        brk_next = BRK_SEEN;
                    end else if (brk_reg == BRK_SEEN) begin
                        if (rx_byte == RESET_CHAR) begin
                            brk_next = BRK_RESET;
                            pulse    = 1'b1;
                        end else begin
                            brk_next = BRK_IDLE;
                        end
                    end
                    if (push) begin
                        wp_next = wp_inc;
                    end
                end
                CMD_READ: begin
                    if (pop) begin
                        rp_next = rp_inc;
                    end
                end
                CMD_PEEK: begin
                end
                CMD_CLEAR: begin
                    rp_next = wp_reg;
                end
                default: begin
                end
            endcase
        end
    end

    assign fill_raw = ({1'b0, wp_next} - {1'b0, rp_next})
                      + ((wp_next < rp_next) ? DEPTH_C : '0);

    urx_brk_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FIFO_DEPTH),
        .AW    (PW)
    ) u_fifo_ram (
        .aclk  (aclk),
        .we    (push),
        .waddr (wp_reg),
        .wdata (rx_byte),
        .re    (present),
        .raddr (rp_reg),
        .rdata (rd_data)
    );

    assign out_load = (state_reg == S_DATA) && (!m_valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    state_next = S_DATA;
                end
            end
            S_DATA: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            wp_reg      <= '0;
            rp_reg      <= '0;
            brk_reg     <= BRK_IDLE;
            enabled_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            rp_reg      <= rp_next;
            brk_reg     <= brk_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                enabled_reg <= cfg_data[0];
            end
        end
        if (in_accept) begin
            present_reg <= present;
            fill_reg    <= FILL_W'(fill_raw);
            flag_reg    <= (brk_next == BRK_RESET);
            pulse_reg   <= pulse;
        end
        if (out_load) begin
            m_tdata_reg <= {7'd0, pulse_reg, flag_reg, fill_reg,
                            present_reg ? rd_data : 8'd0};
            m_tuser_reg <= present_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Pointers stay inside the store for any depth
    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, wp_reg} < DEPTH_C) && ({1'b0, rp_reg} < DEPTH_C))
        else $error("FIFO pointer out of range");

    // A clear leaves the FIFO empty
    a_clear_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && cmd == CMD_CLEAR) |=> (wp_reg == rp_reg))
        else $error("clear did not empty FIFO");

    // A command in flight blocks the next until its result is latched
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> !s_tready)
        else $error("second item accepted while one is in flight");

    // Reset pulse only with reset flag
    a_pulse_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[16]) |-> m_tdata[15])
        else $error("reset pulse without reset flag");

    // Data present never reported by an empty FIFO
    a_present_ne: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && (cmd == CMD_READ || cmd == CMD_PEEK) && wp_reg == rp_reg)
        |=> !present_reg)
        else $error("data present from empty FIFO");

endmodule

// File: hw/rtl/urx_brk_ram.sv
module urx_brk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
